// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the alarm queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SADQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define SADQ_ASSERT_NEVER(label, expr, msg) \
    `SADQ_ASSERT(label, !(expr), msg)

`endif

// ===== rtl/sadq_pkg.sv =====
// Shared constants, codes and controller interface types of the alarm queue.
`default_nettype none

package sadq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int TIME_W = 32;
    localparam int TASK_W = 8;
    localparam int CFG_W  = 10;
    localparam int APB_W  = 32;
    localparam int ADDR_W = 3;

    localparam logic [CFG_W-1:0] TICK_MS_RST = 10'd10;
    localparam logic [CFG_W-1:0] TPS_RST     = 10'd100;

    // Register index as decoded from paddr[2].
    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_TICK_MS          = 1'b0;
    localparam reg_idx_t REG_TICKS_PER_SECOND = 1'b1;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_SET_ACK = 2'd0;
    localparam kind_t KIND_WOKEN   = 2'd1;
    localparam kind_t KIND_NO_WAKE = 2'd2;

    typedef struct packed {
        logic  load_set;
        logic  load_tick;
        logic  rd_en;
        logic  rd_prev;
        logic  wr_new;
        logic  wr_shift;
        logic  idx_inc;
        logic  idx_dec;
        logic  pend_load;
        logic  emit;
        kind_t emit_kind;
        logic  emit_last;
        logic  commit_tick;
    } ctl_t;

    typedef struct packed {
        logic full;
        logic idx_zero;
        logic idx_at_count;
        logic entry_due;
        logic entry_ge;
        logic pend_valid;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/sadq_cfg.sv =====
// Configuration register file: tick length and ticks per second.
`default_nettype none

module sadq_cfg
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire sadq_pkg::reg_idx_t           reg_sel,
    input  wire logic [sadq_pkg::APB_W-1:0]   pwdata,
    output logic      [sadq_pkg::APB_W-1:0]   prdata,
    output logic      [sadq_pkg::CFG_W-1:0]   tick_ms,
    output logic      [sadq_pkg::CFG_W-1:0]   ticks_per_second
);

    logic [sadq_pkg::CFG_W-1:0] tick_ms_reg;
    logic [sadq_pkg::CFG_W-1:0] tick_ms_next;
    logic [sadq_pkg::CFG_W-1:0] tps_reg;
    logic [sadq_pkg::CFG_W-1:0] tps_next;
    logic                       wr_beat;

    assign wr_beat = psel && penable && pwrite;

    always_comb
    begin
        tick_ms_next = tick_ms_reg;
        tps_next     = tps_reg;
        if (wr_beat)
        begin
            case (reg_sel)
                sadq_pkg::REG_TICK_MS:          tick_ms_next = pwdata[sadq_pkg::CFG_W-1:0];
                sadq_pkg::REG_TICKS_PER_SECOND: tps_next     = pwdata[sadq_pkg::CFG_W-1:0];
                default:                        tick_ms_next = tick_ms_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ms_reg <= sadq_pkg::TICK_MS_RST;
            tps_reg     <= sadq_pkg::TPS_RST;
        end
        else
        begin
            tick_ms_reg <= tick_ms_next;
            tps_reg     <= tps_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            sadq_pkg::REG_TICK_MS:
                prdata = sadq_pkg::APB_W'(tick_ms_reg);
            sadq_pkg::REG_TICKS_PER_SECOND:
                prdata = sadq_pkg::APB_W'(tps_reg);
            default:
                prdata = '0;
        endcase
    end

    assign tick_ms          = tick_ms_reg;
    assign ticks_per_second = tps_reg;

endmodule

`default_nettype wire

// ===== rtl/sadq_ctrl.sv =====
// Controller state machine: sequences insertion walks, tick walks and result beats.
`default_nettype none

module sadq_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_cmd,
    output logic                   in_ready,
    input  wire sadq_pkg::status_t st,
    output sadq_pkg::ctl_t         ctl
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_ACK     = 3'd3;
    localparam logic [2:0] S_TCK_RD  = 3'd4;
    localparam logic [2:0] S_TCK_CMP = 3'd5;
    localparam logic [2:0] S_TCK_FIN = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_cmd == sadq_pkg::CMD_SET)
                    begin
                        ctl.load_set = 1'b1;
                        state_next   = st.full ? S_ACK : S_INS_RD;
                    end
                    else
                    begin
                        ctl.load_tick = 1'b1;
                        state_next    = S_TCK_RD;
                    end
                end
            end
            // Walk back from the tail, moving entries up until the slot is found.
            S_INS_RD:
            begin
                if (st.idx_zero)
                begin
                    ctl.wr_new = 1'b1;
                    state_next = S_ACK;
                end
                else
                begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_prev = 1'b1;
                    state_next  = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (st.entry_ge)
                begin
                    ctl.wr_shift = 1'b1;
                    ctl.idx_dec  = 1'b1;
                    state_next   = S_INS_RD;
                end
                else
                begin
                    ctl.wr_new = 1'b1;
                    state_next = S_ACK;
                end
            end
            S_ACK:
            begin
                if (st.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = sadq_pkg::KIND_SET_ACK;
                    ctl.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_TCK_RD:
            begin
                if (st.idx_at_count)
                begin
                    state_next = S_TCK_FIN;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    state_next = S_TCK_CMP;
                end
            end
            // Hold one woken task back until we know whether another follows.
            S_TCK_CMP:
            begin
                if (!st.entry_due)
                begin
                    state_next = S_TCK_FIN;
                end
                else if (!st.pend_valid || st.out_free)
                begin
                    ctl.emit      = st.pend_valid;
                    ctl.emit_kind = sadq_pkg::KIND_WOKEN;
                    ctl.pend_load = 1'b1;
                    ctl.idx_inc   = 1'b1;
                    state_next    = S_TCK_RD;
                end
            end
            S_TCK_FIN:
            begin
                if (st.out_free)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_kind   = st.pend_valid ? sadq_pkg::KIND_WOKEN
                                                    : sadq_pkg::KIND_NO_WAKE;
                    ctl.emit_last   = 1'b1;
                    ctl.commit_tick = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sadq_dp.sv =====
// Datapath: circular alarm memory, walk index, time counters and result register.
`default_nettype none

module sadq_dp
#(
    parameter int QUEUE_DEPTH = sadq_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sadq_pkg::ctl_t                ctl,
    output sadq_pkg::status_t                  st,
    input  wire logic [sadq_pkg::TASK_W-1:0]   task_id,
    input  wire logic [sadq_pkg::TIME_W-1:0]   delay_ms,
    input  wire logic [sadq_pkg::CFG_W-1:0]    tick_ms,
    input  wire logic [sadq_pkg::CFG_W-1:0]    ticks_per_second,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output sadq_pkg::kind_t                    kind,
    output logic      [sadq_pkg::TASK_W-1:0]   woken_task,
    output logic                               queue_full,
    output logic      [sadq_pkg::TIME_W-1:0]   seconds_now,
    output logic                               last
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int TW = sadq_pkg::TIME_W;
    localparam int KW = sadq_pkg::TASK_W;
    localparam int FW = sadq_pkg::CFG_W;

    // Keys are stored as deadlines against a running time base; the
    // remaining time of a live entry is key minus base.
    logic [TW-1:0] key_mem  [QUEUE_DEPTH];
    logic [KW-1:0] task_mem [QUEUE_DEPTH];

    logic [CW-1:0] count_reg,   count_next;
    logic [AW-1:0] head_reg,    head_next;
    logic [CW-1:0] idx_reg,     idx_next;
    logic [TW-1:0] base_reg,    base_next;
    logic [FW-1:0] subsec_reg,  subsec_next;
    logic [TW-1:0] seconds_reg, seconds_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          out_valid_reg,  out_valid_next;

    logic [TW-1:0]       delay_reg,   delay_next;
    logic [KW-1:0]       task_reg,    task_next;
    logic                full_reg,    full_next;
    logic [KW-1:0]       pend_task_reg, pend_task_next;
    sadq_pkg::kind_t     kind_reg,    kind_next;
    logic [KW-1:0]       woken_reg,   woken_next;
    logic                qfull_reg,   qfull_next;
    logic [TW-1:0]       secs_out_reg, secs_out_next;
    logic                last_reg,    last_next;

    logic [TW-1:0] rd_key_reg;
    logic [KW-1:0] rd_task_reg;

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] idx_prev;
    logic          wr_en;
    logic [TW-1:0] wr_key;
    logic [KW-1:0] wr_task;
    logic [TW-1:0] remaining;
    logic [FW-1:0] subsec_inc;
    logic          out_free;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] pos);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(pos);
        if (sum >= SW'(QUEUE_DEPTH))
        begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign idx_prev = idx_reg - CW'(1);
    assign wr_addr  = phys(head_reg, idx_reg);
    assign rd_addr  = ctl.rd_prev ? phys(head_reg, idx_prev) : phys(head_reg, idx_reg);
    assign wr_en    = ctl.wr_new || ctl.wr_shift;
    assign wr_key   = ctl.wr_new ? (delay_reg + base_reg) : rd_key_reg;
    assign wr_task  = ctl.wr_new ? task_reg : rd_task_reg;

    assign remaining  = rd_key_reg - base_reg;
    assign subsec_inc = subsec_reg + FW'(1);
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        st.full         = (count_reg == CW'(QUEUE_DEPTH));
        st.idx_zero     = (idx_reg == '0);
        st.idx_at_count = (idx_reg == count_reg);
        st.entry_due    = (remaining <= TW'(tick_ms));
        st.entry_ge     = (remaining >= delay_reg);
        st.pend_valid   = pend_valid_reg;
        st.out_free     = out_free;
    end

    always_comb
    begin
        count_next      = count_reg;
        head_next       = head_reg;
        idx_next        = idx_reg;
        base_next       = base_reg;
        subsec_next     = subsec_reg;
        seconds_next    = seconds_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        delay_next      = delay_reg;
        task_next       = task_reg;
        full_next       = full_reg;
        pend_task_next  = pend_task_reg;
        kind_next       = kind_reg;
        woken_next      = woken_reg;
        qfull_next      = qfull_reg;
        secs_out_next   = secs_out_reg;
        last_next       = last_reg;

        if (ctl.load_set)
        begin
            delay_next = delay_ms;
            task_next  = task_id;
            full_next  = st.full;
            idx_next   = count_reg;
        end

        if (ctl.load_tick)
        begin
            idx_next        = '0;
            pend_valid_next = 1'b0;
            // Roll the sub-second count; a zero limit rolls on every tick.
            if (subsec_inc >= ticks_per_second)
            begin
                subsec_next  = '0;
                seconds_next = seconds_reg + TW'(1);
            end
            else
            begin
                subsec_next = subsec_inc;
            end
        end

        if (ctl.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
        if (ctl.idx_dec)
        begin
            idx_next = idx_prev;
        end

        if (ctl.wr_new)
        begin
            count_next = count_reg + CW'(1);
        end

        if (ctl.pend_load)
        begin
            pend_valid_next = 1'b1;
            pend_task_next  = rd_task_reg;
        end

        // Drop the woken prefix and advance the time base.
        if (ctl.commit_tick)
        begin
            head_next  = wr_addr;
            count_next = count_reg - idx_reg;
            base_next  = base_reg + TW'(tick_ms);
        end

        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
            kind_next      = ctl.emit_kind;
            woken_next     = (ctl.emit_kind == sadq_pkg::KIND_WOKEN) ? pend_task_reg : '0;
            qfull_next     = (ctl.emit_kind == sadq_pkg::KIND_SET_ACK) ? full_reg : 1'b0;
            secs_out_next  = seconds_reg;
            last_next      = ctl.emit_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            head_reg       <= '0;
            idx_reg        <= '0;
            base_reg       <= '0;
            subsec_reg     <= '0;
            seconds_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            head_reg       <= head_next;
            idx_reg        <= idx_next;
            base_reg       <= base_next;
            subsec_reg     <= subsec_next;
            seconds_reg    <= seconds_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delay_reg     <= delay_next;
        task_reg      <= task_next;
        full_reg      <= full_next;
        pend_task_reg <= pend_task_next;
        kind_reg      <= kind_next;
        woken_reg     <= woken_next;
        qfull_reg     <= qfull_next;
        secs_out_reg  <= secs_out_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]  <= wr_key;
            task_mem[wr_addr] <= wr_task;
        end
        if (ctl.rd_en)
        begin
            rd_key_reg  <= key_mem[rd_addr];
            rd_task_reg <= task_mem[rd_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign woken_task  = woken_reg;
    assign queue_full  = qfull_reg;
    assign seconds_now = secs_out_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// ===== rtl/sorted_alarm_delta_queue.sv =====
// Sorted alarm delta queue: a deadline-ordered table of task wake-up alarms.
// Input channel (in_valid/in_ready) carries one item per beat: cmd selects a
// tick or a set-alarm with task_id and delay_ms. Output channel
// (out_valid/out_ready) returns result beats; last marks the final beat of an item.
// A set gives one beat (kind 0, queue_full when the table was full).
// A tick gives one beat per woken task (kind 1) in deadline order, or one kind 2 beat.
// A set walks back from the tail of the table, moving alarms up one slot until
// the slot of the new alarm is found; a full table skips the walk. A tick walks
// from the head until it meets an alarm that is not yet due. The alarm memory
// has a single read port, so each walk visits one entry at a time: read it,
// then compare it (and, for a set, write it back one slot up).
// One item is in work at a time; the next is taken once the last result of
// the current one sits in the output register.
// A stalled receiver holds the result register; a tick that wakes several
// tasks pauses its walk until the previous beat is taken.
// Reset empties the table, clears the tick and seconds counts and loads
// tick_ms = 10 and ticks_per_second = 100 (APB offsets 0 and 4).
`default_nettype none
`include "assert_macros.svh"

module sorted_alarm_delta_queue
#(
    parameter int QUEUE_DEPTH = sadq_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sadq_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [sadq_pkg::APB_W-1:0]    pwdata,
    output logic      [sadq_pkg::APB_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic [sadq_pkg::TASK_W-1:0]   task_id,
    input  wire logic [sadq_pkg::TIME_W-1:0]   delay_ms,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [1:0]                    kind,
    output logic      [sadq_pkg::TASK_W-1:0]   woken_task,
    output logic                               queue_full,
    output logic      [sadq_pkg::TIME_W-1:0]   seconds_now,
    output logic                               last
);

    sadq_pkg::ctl_t              ctl;
    sadq_pkg::status_t           st;
    sadq_pkg::kind_t             kind_w;
    logic [sadq_pkg::CFG_W-1:0]  tick_ms;
    logic [sadq_pkg::CFG_W-1:0]  ticks_per_second;

    assign pready = 1'b1;
    assign kind   = kind_w;

    sadq_cfg u_cfg
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .reg_sel          (paddr[2]),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .tick_ms          (tick_ms),
        .ticks_per_second (ticks_per_second)
    );

    sadq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (cmd),
        .in_ready (in_ready),
        .st       (st),
        .ctl      (ctl)
    );

    sadq_dp
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .st               (st),
        .task_id          (task_id),
        .delay_ms         (delay_ms),
        .tick_ms          (tick_ms),
        .ticks_per_second (ticks_per_second),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind_w),
        .woken_task       (woken_task),
        .queue_full       (queue_full),
        .seconds_now      (seconds_now),
        .last             (last)
    );

    `SADQ_ASSERT(a_one_item_at_a_time, in_valid && in_ready |=> !in_ready, "item taken while busy")
    `SADQ_ASSERT_NEVER(a_no_result_overrun, ctl.emit && out_valid && !out_ready, "result overrun")
    `SADQ_ASSERT(a_commit_last, ctl.commit_tick |-> ctl.emit && ctl.emit_last, "stray tick commit")
    `SADQ_ASSERT(a_back_to_idle, ctl.emit && ctl.emit_last |=> in_ready, "not idle after last beat")

endmodule

`default_nettype wire
